// ----- sv/assert_macros.svh -----
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: invariant");

// Check that a trigger is followed by a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("assertion failed: sequence");

`endif

// ----- sv/spfsl_pkg.sv -----
`timescale 1ns / 1ps

package spfsl_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned PRI_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS  = 3'd0,
    CMD_APP  = 3'd1,
    CMD_PUSH = 3'd2,
    CMD_REM  = 3'd3,
    CMD_DEL  = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

endpackage

// ----- sv/spfsl_mem.sv -----
`timescale 1ns / 1ps

module spfsl_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                          clk,
  input  logic                          data_we,
  input  logic [AW-1:0]                 data_waddr,
  input  logic [spfsl_pkg::KEY_W-1:0]   data_wkey,
  input  logic [spfsl_pkg::PRI_W-1:0]   data_wpri,
  input  logic                          link_we,
  input  logic [AW-1:0]                 link_waddr,
  input  logic [AW-1:0]                 link_wdata,
  input  logic [AW-1:0]                 raddr,
  output logic [spfsl_pkg::KEY_W-1:0]   rd_key,
  output logic [spfsl_pkg::PRI_W-1:0]   rd_pri,
  output logic [AW-1:0]                 rd_link
);

  logic [spfsl_pkg::KEY_W+spfsl_pkg::PRI_W-1:0] data_mem [DEPTH];
  logic [AW-1:0]                                link_mem [DEPTH];
  logic [spfsl_pkg::KEY_W+spfsl_pkg::PRI_W-1:0] data_q;

  // Entry payload store with a registered read.
  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[data_waddr] <= {data_wpri, data_wkey};
    end
    data_q <= data_mem[raddr];
  end

  // Successor links, read at the same address as the payload.
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    rd_link <= link_mem[raddr];
  end

  assign rd_key = data_q[spfsl_pkg::KEY_W-1:0];
  assign rd_pri = data_q[spfsl_pkg::KEY_W+spfsl_pkg::PRI_W-1:spfsl_pkg::KEY_W];

endmodule

// ----- sv/spfsl_ctrl.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spfsl_ctrl #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned CW    = 5
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [spfsl_pkg::CMD_W-1:0]     in_cmd,
  input  logic [spfsl_pkg::KEY_W-1:0]     in_key,
  input  logic [spfsl_pkg::PRI_W-1:0]     in_pri,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [spfsl_pkg::STATUS_W-1:0]  out_status,
  output logic [spfsl_pkg::KEY_W-1:0]     out_key,
  output logic [spfsl_pkg::PRI_W-1:0]     out_pri,
  output logic [spfsl_pkg::OCC_W-1:0]     out_occ,
  output logic                            data_we,
  output logic [AW-1:0]                   data_waddr,
  output logic [spfsl_pkg::KEY_W-1:0]     data_wkey,
  output logic [spfsl_pkg::PRI_W-1:0]     data_wpri,
  output logic                            link_we,
  output logic [AW-1:0]                   link_waddr,
  output logic [AW-1:0]                   link_wdata,
  output logic [AW-1:0]                   raddr,
  input  logic [spfsl_pkg::KEY_W-1:0]     rd_key,
  input  logic [spfsl_pkg::PRI_W-1:0]     rd_pri,
  input  logic [AW-1:0]                   rd_link
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_ALLOC_RD = 8'b0000_0010,
    S_ALLOC_EX = 8'b0000_0100,
    S_PLACE    = 8'b0000_1000,
    S_WALK_RD  = 8'b0001_0000,
    S_WALK_EX  = 8'b0010_0000,
    S_LINK2    = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t                           state_r, state_nxt;
  logic [spfsl_pkg::CMD_W-1:0]      cmd_r, cmd_nxt;
  logic [spfsl_pkg::KEY_W-1:0]      key_r, key_nxt;
  logic [spfsl_pkg::PRI_W-1:0]      pri_r, pri_nxt;
  logic [spfsl_pkg::STATUS_W-1:0]   status_r, status_nxt;
  logic [spfsl_pkg::KEY_W-1:0]      okey_r, okey_nxt;
  logic [spfsl_pkg::PRI_W-1:0]      opri_r, opri_nxt;
  logic [AW-1:0]                    head_r, head_nxt;
  logic [AW-1:0]                    tail_r, tail_nxt;
  logic [AW-1:0]                    free_r, free_nxt;
  logic [AW-1:0]                    cur_r, cur_nxt;
  logic [AW-1:0]                    prev_r, prev_nxt;
  logic [AW-1:0]                    node_r, node_nxt;
  logic                             prev_ok_r, prev_ok_nxt;
  logic [CW-1:0]                    cnt_r, cnt_nxt;
  logic [CW-1:0]                    fill_r, fill_nxt;
  logic [CW-1:0]                    idx_r, idx_nxt;
  logic                             ov_r, ov_nxt;
  logic [spfsl_pkg::STATUS_W-1:0]   ostat_r, ostat_nxt;
  logic [spfsl_pkg::KEY_W-1:0]      okey_out_r, okey_out_nxt;
  logic [spfsl_pkg::PRI_W-1:0]      opri_out_r, opri_out_nxt;
  logic [spfsl_pkg::OCC_W-1:0]      occ_r, occ_nxt;
  logic                             last_node;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_status = ostat_r;
  assign out_key    = okey_out_r;
  assign out_pri    = opri_out_r;
  assign out_occ    = occ_r;
  assign last_node  = ((idx_r + CW'(1)) == cnt_r);

  // Sequencer: allocation, list walk and link updates.
  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    key_nxt      = key_r;
    pri_nxt      = pri_r;
    status_nxt   = status_r;
    okey_nxt     = okey_r;
    opri_nxt     = opri_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    free_nxt     = free_r;
    cur_nxt      = cur_r;
    prev_nxt     = prev_r;
    node_nxt     = node_r;
    prev_ok_nxt  = prev_ok_r;
    cnt_nxt      = cnt_r;
    fill_nxt     = fill_r;
    idx_nxt      = idx_r;
    ov_nxt       = ov_r & ~out_tready;
    ostat_nxt    = ostat_r;
    okey_out_nxt = okey_out_r;
    opri_out_nxt = opri_out_r;
    occ_nxt      = occ_r;
    data_we      = 1'b0;
    data_waddr   = node_r;
    data_wkey    = key_r;
    data_wpri    = pri_r;
    link_we      = 1'b0;
    link_waddr   = cur_r;
    link_wdata   = free_r;
    raddr        = cur_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt     = in_cmd;
          key_nxt     = in_key;
          pri_nxt     = (in_cmd == spfsl_pkg::CMD_INS) ? in_pri : '0;
          status_nxt  = spfsl_pkg::ST_OK;
          okey_nxt    = '0;
          opri_nxt    = '0;
          cur_nxt     = head_r;
          prev_ok_nxt = 1'b0;
          idx_nxt     = '0;
          case (in_cmd)
            spfsl_pkg::CMD_INS, spfsl_pkg::CMD_APP, spfsl_pkg::CMD_PUSH: begin
              if (cnt_r == CW'(DEPTH)) begin
                status_nxt = spfsl_pkg::ST_FULL;
                state_nxt  = S_DONE;
              end else if (fill_r < CW'(DEPTH)) begin
                node_nxt  = AW'(fill_r);
                fill_nxt  = fill_r + CW'(1);
                state_nxt = S_PLACE;
              end else begin
                state_nxt = S_ALLOC_RD;
              end
            end
            spfsl_pkg::CMD_REM, spfsl_pkg::CMD_DEL: begin
              if (cnt_r == '0) begin
                status_nxt = spfsl_pkg::ST_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_WALK_RD;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Pop a recycled entry from the free list.
      S_ALLOC_RD: begin
        raddr     = free_r;
        state_nxt = S_ALLOC_EX;
      end

      S_ALLOC_EX: begin
        node_nxt  = free_r;
        free_nxt  = rd_link;
        state_nxt = S_PLACE;
      end

      // Write the new entry and link it where no search is needed.
      S_PLACE: begin
        data_we = 1'b1;
        case (cmd_r)
          spfsl_pkg::CMD_APP: begin
            if (cnt_r == '0) begin
              head_nxt = node_r;
            end else begin
              link_we    = 1'b1;
              link_waddr = tail_r;
              link_wdata = node_r;
            end
            tail_nxt  = node_r;
            cnt_nxt   = cnt_r + CW'(1);
            state_nxt = S_DONE;
          end
          spfsl_pkg::CMD_PUSH: begin
            link_we    = 1'b1;
            link_waddr = node_r;
            link_wdata = head_r;
            head_nxt   = node_r;
            if (cnt_r == '0) begin
              tail_nxt = node_r;
            end
            cnt_nxt   = cnt_r + CW'(1);
            state_nxt = S_DONE;
          end
          default: begin
            if (cnt_r == '0) begin
              head_nxt  = node_r;
              tail_nxt  = node_r;
              cnt_nxt   = cnt_r + CW'(1);
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_WALK_RD;
            end
          end
        endcase
      end

      S_WALK_RD: begin
        state_nxt = S_WALK_EX;
      end

      // Examine the entry just read and decide whether the walk stops here.
      S_WALK_EX: begin
        case (cmd_r)
          spfsl_pkg::CMD_REM: begin
            okey_nxt   = rd_key;
            opri_nxt   = rd_pri;
            head_nxt   = rd_link;
            link_we    = 1'b1;
            link_waddr = cur_r;
            link_wdata = free_r;
            free_nxt   = cur_r;
            cnt_nxt    = cnt_r - CW'(1);
            state_nxt  = S_DONE;
          end
          spfsl_pkg::CMD_INS: begin
            if ($signed(rd_pri) < $signed(pri_r)) begin
              link_we    = 1'b1;
              link_waddr = node_r;
              link_wdata = cur_r;
              state_nxt  = S_LINK2;
            end else if (last_node) begin
              link_we    = 1'b1;
              link_waddr = cur_r;
              link_wdata = node_r;
              tail_nxt   = node_r;
              cnt_nxt    = cnt_r + CW'(1);
              state_nxt  = S_DONE;
            end else begin
              prev_nxt    = cur_r;
              prev_ok_nxt = 1'b1;
              cur_nxt     = rd_link;
              idx_nxt     = idx_r + CW'(1);
              state_nxt   = S_WALK_RD;
            end
          end
          default: begin
            if (rd_key == key_r) begin
              if (prev_ok_r) begin
                link_we    = 1'b1;
                link_waddr = prev_r;
                link_wdata = rd_link;
              end else begin
                head_nxt = rd_link;
              end
              if (cur_r == tail_r) begin
                tail_nxt = prev_r;
              end
              state_nxt = S_LINK2;
            end else if (last_node) begin
              status_nxt = spfsl_pkg::ST_NOTFOUND;
              state_nxt  = S_DONE;
            end else begin
              prev_nxt    = cur_r;
              prev_ok_nxt = 1'b1;
              cur_nxt     = rd_link;
              idx_nxt     = idx_r + CW'(1);
              state_nxt   = S_WALK_RD;
            end
          end
        endcase
      end

      // Second link write: splice in the new entry (or make it the head) or recycle the deleted one.
      S_LINK2: begin
        link_we = 1'b1;
        if (cmd_r == spfsl_pkg::CMD_INS) begin
          if (prev_ok_r) begin
            link_waddr = prev_r;
            link_wdata = node_r;
          end else begin
            link_we  = 1'b0;
            head_nxt = node_r;
          end
          cnt_nxt = cnt_r + CW'(1);
        end else begin
          link_waddr = cur_r;
          link_wdata = free_r;
          free_nxt   = cur_r;
          cnt_nxt    = cnt_r - CW'(1);
        end
        state_nxt = S_DONE;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!ov_r || out_tready) begin
          ov_nxt       = 1'b1;
          ostat_nxt    = status_r;
          okey_out_nxt = okey_r;
          opri_out_nxt = opri_r;
          occ_nxt      = spfsl_pkg::OCC_W'(cnt_r);
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      fill_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      fill_r  <= fill_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Pointers and payload.
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    pri_r      <= pri_nxt;
    status_r   <= status_nxt;
    okey_r     <= okey_nxt;
    opri_r     <= opri_nxt;
    head_r     <= head_nxt;
    tail_r     <= tail_nxt;
    free_r     <= free_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    node_r     <= node_nxt;
    prev_ok_r  <= prev_ok_nxt;
    idx_r      <= idx_nxt;
    ostat_r    <= ostat_nxt;
    okey_out_r <= okey_out_nxt;
    opri_out_r <= opri_out_nxt;
    occ_r      <= occ_nxt;
  end

  `ASSERT_ALWAYS(a_cnt_le_fill, clk, rst_n, cnt_r <= fill_r)
  `ASSERT_ALWAYS(a_fill_le_depth, clk, rst_n, fill_r <= CW'(DEPTH))
  `ASSERT_NEXT(a_accept_busy, clk, rst_n, in_tvalid && in_tready, state_r != S_IDLE)
  `ASSERT_NEXT(a_cnt_step, clk, rst_n, 1'b1, (cnt_r == $past(cnt_r)) || (cnt_r == $past(cnt_r) + CW'(1)) || (cnt_r == $past(cnt_r) - CW'(1)))

endmodule

// ----- sv/shared_priority_fifo_stack_list.sv -----
`timescale 1ns / 1ps
// Shared ordered store serving priority insert, tail append, head push,
// head remove and delete by key on one list of up to DEPTH entries.
// Input channel in_*: one command per transfer; tdata carries cmd, key and
// priority_req. Output channel out_*: exactly one result per command with
// status, removed key and priority, and the occupancy after the command.
// Entries live in two memories (payload and successor link), each with one
// write port and a registered read; the list is kept as a linked
// chain with a free list.
// Path from the accepting edge to out_tvalid, ending in S_DONE: rejected and
// unused commands go there at once; append and push pass S_PLACE, after
// S_ALLOC_RD and S_ALLOC_EX when a recycled entry is taken; head remove
// passes S_WALK_RD and S_WALK_EX; insert and delete walk the chain over the
// memory read port, one S_WALK_RD/S_WALK_EX pair per entry visited. The next
// command is taken in the cycle after the result is loaded; one is in flight.
// Reset empties the store at once (no clearing pass); memory contents stay
// undefined until written. When the receiver stalls, the result waits in the
// output register and the block accepts one more command, which finishes
// its work and waits until that register is taken.
module shared_priority_fifo_stack_list #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] cmd, [34:3] key, [50:35] priority_req, [55:51] zero
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] status, [33:2] out_key, [49:34] out_priority, [54:50] occupancy
  output logic [55:0] out_tdata
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [spfsl_pkg::STATUS_W-1:0] o_status;
  logic [spfsl_pkg::KEY_W-1:0]    o_key;
  logic [spfsl_pkg::PRI_W-1:0]    o_pri;
  logic [spfsl_pkg::OCC_W-1:0]    o_occ;
  logic                           data_we;
  logic [AW-1:0]                  data_waddr;
  logic [spfsl_pkg::KEY_W-1:0]    data_wkey;
  logic [spfsl_pkg::PRI_W-1:0]    data_wpri;
  logic                           link_we;
  logic [AW-1:0]                  link_waddr;
  logic [AW-1:0]                  link_wdata;
  logic [AW-1:0]                  raddr;
  logic [spfsl_pkg::KEY_W-1:0]    rd_key;
  logic [spfsl_pkg::PRI_W-1:0]    rd_pri;
  logic [AW-1:0]                  rd_link;

  // Result packing, lowest field last in the concatenation.
  assign out_tdata = {1'b0, o_occ, o_pri, o_key, o_status};

  spfsl_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tdata[2:0]),
    .in_key     (in_tdata[34:3]),
    .in_pri     (in_tdata[50:35]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (o_status),
    .out_key    (o_key),
    .out_pri    (o_pri),
    .out_occ    (o_occ),
    .data_we    (data_we),
    .data_waddr (data_waddr),
    .data_wkey  (data_wkey),
    .data_wpri  (data_wpri),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .raddr      (raddr),
    .rd_key     (rd_key),
    .rd_pri     (rd_pri),
    .rd_link    (rd_link)
  );

  spfsl_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk        (clk),
    .data_we    (data_we),
    .data_waddr (data_waddr),
    .data_wkey  (data_wkey),
    .data_wpri  (data_wpri),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .raddr      (raddr),
    .rd_key     (rd_key),
    .rd_pri     (rd_pri),
    .rd_link    (rd_link)
  );

endmodule

// ----- test/tb_shared_priority_fifo_stack_list.sv -----
`timescale 1ns / 1ps
module tb_shared_priority_fifo_stack_list;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned CMD_W = spfsl_pkg::CMD_W;
  localparam int unsigned KEY_W = spfsl_pkg::KEY_W;
  localparam int unsigned PRI_W = spfsl_pkg::PRI_W;
  localparam int unsigned OCC_W = spfsl_pkg::OCC_W;

  // Lowest field last, so the layout matches out_tdata[54:0].
  typedef struct packed {
    logic [OCC_W-1:0]     occ;
    logic [PRI_W-1:0]     pri;
    logic [KEY_W-1:0]     key;
    spfsl_pkg::status_t   status;
  } result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // [2:0] cmd, [34:3] key, [50:35] priority_req, [55:51] zero
  logic [55:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  // [1:0] status, [33:2] out_key, [49:34] out_priority, [54:50] occupancy
  logic [55:0] out_tdata;

  // Shadow copy of the ordered store.
  logic [KEY_W-1:0]        list_keys[$];
  logic signed [PRI_W-1:0] list_pris[$];
  result_t                 pending_results[$];

  int unsigned error_count;
  int unsigned sent_count;
  int unsigned result_count;
  int unsigned idle_cycles;
  bit          hold_off;
  bit          random_stall;

  shared_priority_fifo_stack_list #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Work out the result of one command and update the shadow store.
  function automatic result_t apply_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                            logic signed [PRI_W-1:0] pri);
    result_t r;
    int pos;
    r = '0;
    r.status = spfsl_pkg::ST_OK;
    case (cmd)
      spfsl_pkg::CMD_INS, spfsl_pkg::CMD_APP, spfsl_pkg::CMD_PUSH: begin
        if (list_keys.size() >= DEPTH) begin
          r.status = spfsl_pkg::ST_FULL;
        end else if (cmd == spfsl_pkg::CMD_INS) begin
          pos = list_keys.size();
          for (int i = 0; i < list_keys.size(); i++) begin
            if (list_pris[i] < pri) begin
              pos = i;
              break;
            end
          end
          list_keys.insert(pos, key);
          list_pris.insert(pos, pri);
        end else if (cmd == spfsl_pkg::CMD_APP) begin
          list_keys.push_back(key);
          list_pris.push_back('0);
        end else begin
          list_keys.push_front(key);
          list_pris.push_front('0);
        end
      end
      spfsl_pkg::CMD_REM: begin
        if (list_keys.size() == 0) begin
          r.status = spfsl_pkg::ST_EMPTY;
        end else begin
          r.key = list_keys.pop_front();
          r.pri = list_pris.pop_front();
        end
      end
      spfsl_pkg::CMD_DEL: begin
        if (list_keys.size() == 0) begin
          r.status = spfsl_pkg::ST_EMPTY;
        end else begin
          pos = -1;
          for (int i = 0; i < list_keys.size(); i++) begin
            if (list_keys[i] == key) begin
              pos = i;
              break;
            end
          end
          if (pos < 0) begin
            r.status = spfsl_pkg::ST_NOTFOUND;
          end else begin
            list_keys.delete(pos);
            list_pris.delete(pos);
          end
        end
      end
      default: ;
    endcase
    r.occ = OCC_W'(list_keys.size());
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
    $display("MISMATCH result %0d %s: got %0h expected %0h", result_count, what, got, want);
    error_count++;
  endtask

  // Send one command; the sender waits a random gap first unless use_gap is clear.
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                              logic signed [PRI_W-1:0] pri, bit use_gap = 1'b1);
    int gap;
    gap = use_gap ? $urandom_range(0, 15) : 0;
    if (gap > 0 && $urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(negedge clk);
    in_tdata  = {5'b0, pri, key, cmd};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_command(cmd, key, pri));
    sent_count++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (2 * DEPTH + 10) @(negedge clk);
  endtask

  // Receiver: random stalls when random_stall is set, or a long hold-off when requested.
  initial begin
    int gap;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
      end else if (random_stall && !out_tready && $urandom_range(0, 1)) begin
        gap = $urandom_range(0, 15);
        repeat (gap) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= !random_stall || $urandom_range(0, 3) != 0;
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[54:0];
      if (pending_results.size() == 0) begin
        $display("MISMATCH result %0d arrived with nothing expected", result_count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[55] !== 1'b0) report_mismatch("pad", KEY_W'(out_tdata[55]), '0);
        if (got.status !== want.status)
          report_mismatch("status", KEY_W'(got.status), KEY_W'(want.status));
        if (got.key !== want.key) report_mismatch("key", got.key, want.key);
        if (got.pri !== want.pri)
          report_mismatch("priority", KEY_W'(got.pri), KEY_W'(want.pri));
        if (got.occ !== want.occ)
          report_mismatch("occupancy", KEY_W'(got.occ), KEY_W'(want.occ));
      end
      result_count++;
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_shared_priority_fifo_stack_list failed");
        $finish;
      end
    end
  end

  function automatic logic [KEY_W-1:0] pick_key();
    if (list_keys.size() != 0 && $urandom_range(0, 3) != 0)
      return list_keys[$urandom_range(0, list_keys.size() - 1)];
    return $urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(0, 31);
  endfunction

  function automatic logic [PRI_W-1:0] pick_priority();
    case ($urandom_range(0, 3))
      0: return PRI_W'($urandom());
      1: return PRI_W'($urandom_range(0, 4) - 2);
      2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return PRI_W'($urandom_range(0, 7));
    endcase
  endfunction

  // Empty store, full store, extreme fields, all commands.
  task automatic test_directed();
    send_command(spfsl_pkg::CMD_REM, '0, '0);
    send_command(spfsl_pkg::CMD_DEL, 32'hffffffff, '0);
    send_command(spfsl_pkg::CMD_INS, 32'hffffffff, 16'sh7fff);
    send_command(spfsl_pkg::CMD_INS, 32'h00000000, -16'sh8000);
    send_command(spfsl_pkg::CMD_INS, 32'haaaaaaaa, 16'sh0000);
    send_command(spfsl_pkg::CMD_INS, 32'h55555555, 16'sh0000);
    send_command(spfsl_pkg::CMD_APP, 32'h12345678, 16'sh5555);
    send_command(spfsl_pkg::CMD_PUSH, 32'h87654321, -16'sh5556);
    send_command(spfsl_pkg::CMD_DEL, 32'hdeadbeef, '0);
    send_command(spfsl_pkg::CMD_DEL, 32'haaaaaaaa, '0);
    send_command(3'd5, 32'h1, 16'sh1);
    send_command(3'd6, 32'h2, 16'sh2);
    send_command(3'd7, 32'h3, 16'sh3);
    while (list_keys.size() < DEPTH) send_command(spfsl_pkg::CMD_APP, $urandom(), '0);
    send_command(spfsl_pkg::CMD_INS, 32'h1, 16'sh7fff);
    send_command(spfsl_pkg::CMD_APP, 32'h2, '0);
    send_command(spfsl_pkg::CMD_PUSH, 32'h3, '0);
    send_command(spfsl_pkg::CMD_DEL, list_keys[DEPTH-1], '0);
    repeat (4) send_command(spfsl_pkg::CMD_REM, '0, '0);
  endtask

  // Receiver holds off while commands keep coming, so input backs up.
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      repeat (6) send_command(spfsl_pkg::CMD_INS, $urandom(), pick_priority(), 1'b0);
      begin
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
    join
    wait_drained();
  endtask

  // Random commands biased toward reachable, meaningful states.
  task automatic test_random(int unsigned count);
    int c;
    logic [CMD_W-1:0] cmd;
    for (int n = 0; n < count; n++) begin
      c = $urandom_range(0, 99);
      if (c < 30)      cmd = spfsl_pkg::CMD_INS;
      else if (c < 42) cmd = spfsl_pkg::CMD_APP;
      else if (c < 52) cmd = spfsl_pkg::CMD_PUSH;
      else if (c < 72) cmd = spfsl_pkg::CMD_REM;
      else if (c < 96) cmd = spfsl_pkg::CMD_DEL;
      else             cmd = CMD_W'($urandom_range(5, 7));
      send_command(cmd, pick_key(), pick_priority());
      if (n % 180 == 90) wait_drained();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    hold_off = 1'b0;
    random_stall = 1'b0;
    error_count = 0;
    sent_count = 0;
    result_count = 0;
    idle_cycles = 0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    wait_drained();
    test_backpressure();
    random_stall = 1'b1;
    test_random(270);
    random_stall = 1'b0;
    test_random(250);
    wait_drained();
    if (pending_results.size() != 0) begin
      $display("MISMATCH %0d results never arrived", pending_results.size());
      error_count++;
    end
    $display("Sent %0d commands (insert, append, push, remove, delete, unused codes),",
             sent_count);
    $display("checked %0d results across empty, full and stalled-output conditions.",
             result_count);
    if (error_count == 0) begin
      $display("tb_shared_priority_fifo_stack_list passed");
    end else begin
      $display("tb_shared_priority_fifo_stack_list failed");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+sv
sv/spfsl_pkg.sv
sv/spfsl_mem.sv
sv/spfsl_ctrl.sv
sv/shared_priority_fifo_stack_list.sv
test/tb_shared_priority_fifo_stack_list.sv
